[design/jvns_pkg.sv]
// ----------------------------------------------------------------------------
// Jones vector normalize and split: shared package
// Widths, payload structs, the register map and the rounding helper used by
// the front end, the root cells and the matrix back end.
// ----------------------------------------------------------------------------
package jvns_pkg;

  // Field widths.
  localparam int SampleBits = 16;
  localparam int CoefBits   = 16;
  localparam int CfgBits    = 2 * CoefBits;
  localparam int NumRegs    = 8;
  localparam int CfgIdxBits = $clog2(NumRegs);

  // Root search: q = floor(sqrt(2^62 / E)) fits in SqrtBits bits.
  localparam int SqrtBits   = 18;
  localparam int RemBits    = 63;
  localparam int AccBits    = 70;
  localparam int EnergyBits = 33;
  localparam int SquareBits = 31;

  // Unit vector and matrix sums.
  localparam int ProdUBits  = SampleBits + SqrtBits + 1;
  localparam int UnitBits   = 32;
  localparam int MulBits    = UnitBits + CoefBits;
  localparam int SumBits    = 50;
  localparam int RoundShift = 29;

  // Register map, row-major matrix elements of both paths.
  typedef enum logic [CfgIdxBits-1:0] {
    REG_H_XX, REG_H_XY, REG_H_YX, REG_H_YY,
    REG_V_XX, REG_V_XY, REG_V_YX, REG_V_YY
  } cfg_reg_e;

  // A coefficient of 1.0 in the real half, zero imaginary.
  localparam logic [CfgBits-1:0] CoefOne = CfgBits'(1) << (CfgBits - 2);

  typedef logic signed [SampleBits-1:0] sample_t;

  typedef struct packed {
    logic signed [SampleBits-1:0] x_re;
    logic signed [SampleBits-1:0] x_im;
    logic signed [SampleBits-1:0] y_re;
    logic signed [SampleBits-1:0] y_im;
  } jvns_in_t;

  typedef struct packed {
    logic signed [CoefBits-1:0] one_x_re;
    logic signed [CoefBits-1:0] one_x_im;
    logic signed [CoefBits-1:0] one_y_re;
    logic signed [CoefBits-1:0] one_y_im;
    logic signed [CoefBits-1:0] two_x_re;
    logic signed [CoefBits-1:0] two_x_im;
    logic signed [CoefBits-1:0] two_y_re;
    logic signed [CoefBits-1:0] two_y_im;
    logic                       zero_input;
  } jvns_out_t;

  // What one root cell hands to the next one.
  typedef struct packed {
    logic                      valid;
    logic                      zero;
    sample_t [3:0]             w;
    logic [RemBits-1:0]        rem;
    logic [AccBits-1:0]        acc_x;
    logic [AccBits-1:0]        acc_y;
    logic [SqrtBits-1:0]       root;
  } jvns_cell_t;

  // Round to nearest at bit RoundShift and saturate to a coefficient word.
  function automatic logic [CoefBits-1:0] round_sat(input logic signed [SumBits-1:0] s);
    logic signed [SumBits-1:0] half;
    logic signed [SumBits-1:0] hi;
    logic signed [SumBits-1:0] lo;
    logic signed [SumBits-1:0] r;
    half = SumBits'(1) <<< (RoundShift - 1);
    hi   = (SumBits'(1) <<< (CoefBits - 1)) - SumBits'(1);
    lo   = -(SumBits'(1) <<< (CoefBits - 1));
    r    = (s + half) >>> RoundShift;
    if (r > hi) begin
      r = hi;
    end else if (r < lo) begin
      r = lo;
    end
    return r[CoefBits-1:0];
  endfunction

endpackage

[design/jvns_front.sv]
// ----------------------------------------------------------------------------
// Jones vector normalize and split: front end
// Scales the vector by a common power of two, squares and sums the
// components, and seeds the first root cell.
// ----------------------------------------------------------------------------
module jvns_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                adv_i,
  input  logic                valid_i,
  input  jvns_pkg::jvns_in_t  data_i,
  output jvns_pkg::jvns_cell_t cell_o
);
  import jvns_pkg::*;

  sample_t [3:0]         comp;
  logic [SampleBits-2:0] diff;
  logic [3:0]            shamt;
  logic                  zero;

  logic                  v1_q, v2_q, v3_q;
  logic                  z1_q, z2_q, z3_q;
  sample_t [3:0]         w1_q, w2_q, w3_q;
  logic [SquareBits-1:0] sq_q [4];
  logic [EnergyBits-1:0] energy;
  logic [EnergyBits-1:0] energy_q;

  // Component 0 is x_re, component 3 is y_im.
  assign comp = {data_i.y_im, data_i.y_re, data_i.x_im, data_i.x_re};

  // Redundant sign bits shared by all four components give the shift.
  always_comb begin
    diff = '0;
    zero = 1'b1;
    for (int i = 0; i < 4; i++) begin
      diff = diff | (comp[i][SampleBits-1:1] ^ comp[i][SampleBits-2:0]);
      if (comp[i] != '0) zero = 1'b0;
    end
    shamt = 4'(SampleBits - 1);
    for (int b = 0; b < SampleBits - 1; b++) begin
      if (diff[b]) shamt = 4'(SampleBits - 2 - b);
    end
  end

  assign energy = EnergyBits'(sq_q[0]) + EnergyBits'(sq_q[1])
                + EnergyBits'(sq_q[2]) + EnergyBits'(sq_q[3]);

  // Valid bits of the three front stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (adv_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  // Shift, square, then sum.
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      z1_q <= zero;
      for (int i = 0; i < 4; i++) begin
        w1_q[i] <= comp[i] <<< shamt;
      end
      z2_q <= z1_q;
      w2_q <= w1_q;
      for (int i = 0; i < 4; i++) begin
        sq_q[i] <= SquareBits'($signed(w1_q[i]) * $signed(w1_q[i]));
      end
      z3_q     <= z2_q;
      w3_q     <= w2_q;
      energy_q <= energy;
    end
  end

  // First cell tests the top root bit against 2^62.
  always_comb begin
    cell_o.valid = v3_q;
    cell_o.zero  = z3_q;
    cell_o.w     = w3_q;
    cell_o.rem   = RemBits'(1) << (RemBits - 1);
    cell_o.acc_x = '0;
    cell_o.acc_y = AccBits'(energy_q) << (2 * (SqrtBits - 1));
    cell_o.root  = '0;
  end

endmodule

[design/jvns_cell.sv]
// ----------------------------------------------------------------------------
// Jones vector normalize and split: root cell
// Decides one bit of q = floor(sqrt(2^62 / E)) by testing (q + 2^b)^2 * E
// against 2^62 with running, pre-scaled partial terms.
// ----------------------------------------------------------------------------
module jvns_cell (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 adv_i,
  input  jvns_pkg::jvns_cell_t cell_i,
  output jvns_pkg::jvns_cell_t cell_o
);
  import jvns_pkg::*;

  logic [AccBits-1:0] trial;
  logic               fits;
  jvns_cell_t         next;
  jvns_cell_t         cell_q;
  logic               valid_q;

  // Accept the bit when the added square term still fits the remainder.
  always_comb begin
    trial      = cell_i.acc_x + cell_i.acc_y;
    fits       = trial <= AccBits'(cell_i.rem);
    next       = cell_i;
    next.rem   = fits ? cell_i.rem - trial[RemBits-1:0] : cell_i.rem;
    next.acc_x = (fits ? cell_i.acc_x + (cell_i.acc_y << 1) : cell_i.acc_x) >> 1;
    next.acc_y = cell_i.acc_y >> 2;
    next.root  = {cell_i.root[SqrtBits-2:0], fits};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= cell_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      cell_q <= next;
    end
  end

  // The reset valid bit travels beside the payload.
  always_comb begin
    cell_o       = cell_q;
    cell_o.valid = valid_q;
  end

endmodule

[design/jvns_back.sv]
// ----------------------------------------------------------------------------
// Jones vector normalize and split: matrix back end
// Forms the unit vector, multiplies it by both coefficient matrices, and
// rounds and saturates the eight sums into the output register.
// ----------------------------------------------------------------------------
module jvns_back (
  input  logic                                                clk_i,
  input  logic                                                rst_ni,
  input  logic                                                adv_i,
  input  jvns_pkg::jvns_cell_t                                cell_i,
  input  logic [jvns_pkg::NumRegs-1:0][jvns_pkg::CfgBits-1:0] coef_i,
  output logic                                                valid_o,
  output jvns_pkg::jvns_out_t                                 data_o
);
  import jvns_pkg::*;

  logic                      v1_q, v2_q, vo_q;
  logic                      z1_q, z2_q;
  logic signed [UnitBits-1:0] u_q [4];
  logic signed [MulBits-1:0]  p_q [4][8];
  logic signed [ProdUBits-1:0] pu [4];
  logic [CoefBits-1:0]        res [8];
  logic signed [SumBits-1:0]  s_re, s_im;
  jvns_out_t                  out_q;

  // Unit components u = floor(w * q / 4).
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      pu[i] = $signed(cell_i.w[i]) * $signed({1'b0, cell_i.root});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      vo_q <= 1'b0;
    end else if (adv_i) begin
      v1_q <= cell_i.valid;
      v2_q <= v1_q;
      vo_q <= v2_q;
    end
  end

  // Unit vector, then the complex products for each output row.
  always_ff @(posedge clk_i) begin
    logic signed [CoefBits-1:0] a_re, a_im, b_re, b_im;
    if (adv_i) begin
      z1_q <= cell_i.zero;
      for (int i = 0; i < 4; i++) begin
        u_q[i] <= pu[i][UnitBits+1:2];
      end
      z2_q <= z1_q;
      for (int k = 0; k < 4; k++) begin
        a_re = coef_i[2*k][CfgBits-1:CoefBits];
        a_im = coef_i[2*k][CoefBits-1:0];
        b_re = coef_i[2*k+1][CfgBits-1:CoefBits];
        b_im = coef_i[2*k+1][CoefBits-1:0];
        p_q[k][0] <= u_q[0] * a_re;
        p_q[k][1] <= u_q[1] * a_im;
        p_q[k][2] <= u_q[2] * b_re;
        p_q[k][3] <= u_q[3] * b_im;
        p_q[k][4] <= u_q[0] * a_im;
        p_q[k][5] <= u_q[1] * a_re;
        p_q[k][6] <= u_q[2] * b_im;
        p_q[k][7] <= u_q[3] * b_re;
      end
    end
  end

  // Sum, round and saturate each real and imaginary part.
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      s_re = SumBits'(p_q[k][0]) - SumBits'(p_q[k][1])
           + SumBits'(p_q[k][2]) - SumBits'(p_q[k][3]);
      s_im = SumBits'(p_q[k][4]) + SumBits'(p_q[k][5])
           + SumBits'(p_q[k][6]) + SumBits'(p_q[k][7]);
      res[2*k]   = round_sat(s_re);
      res[2*k+1] = round_sat(s_im);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      out_q.one_x_re   <= res[0];
      out_q.one_x_im   <= res[1];
      out_q.one_y_re   <= res[2];
      out_q.one_y_im   <= res[3];
      out_q.two_x_re   <= res[4];
      out_q.two_x_im   <= res[5];
      out_q.two_y_re   <= res[6];
      out_q.two_y_im   <= res[7];
      out_q.zero_input <= z2_q;
    end
  end

  assign valid_o = vo_q;
  assign data_o  = out_q;

endmodule

[design/jones_vector_normalize_split_unit.sv]
// ----------------------------------------------------------------------------
// Jones vector normalize and split: top level
// Normalizes each Jones vector to unit length and applies two 2x2 complex
// matrices, one per output path.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: in_valid_i / in_stall_o carry one Jones vector per request.
//   Output channel: out_valid_o / out_stall_i carry both path vectors and the
//   zero flag per request; every input request gives one output request.
//   The path from acceptance to the output register runs through three
//   front stages, eighteen root cells (one bit of the reciprocal root each),
//   and three back-end stages for the unit vector, the matrix products and
//   the rounded sums.
//   Throughput is one request per cycle unless stalled; each root cell holds one.
//   The whole pipeline moves when the output register is empty or taken.
//   When the receiver stalls a full output register, the pipeline holds and
//   in_stall_o is raised in the same cycle; nothing is lost.
//   Coefficients are written via cfg_we_i / cfg_index_i / cfg_data_i; the user
//   must write them only while no request is in flight; it is not enforced.
//   Reset clears all valid bits and loads path one with the identity in the
//   first element and path two with the identity in the last element.
// ----------------------------------------------------------------------------
module jones_vector_normalize_split_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  jvns_pkg::jvns_in_t                  in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output jvns_pkg::jvns_out_t                 out_data_o,
  input  logic                                cfg_we_i,
  input  logic [jvns_pkg::CfgIdxBits-1:0]     cfg_index_i,
  input  logic [jvns_pkg::CfgBits-1:0]        cfg_data_i
);
  import jvns_pkg::*;

  logic                             adv;
  logic [NumRegs-1:0][CfgBits-1:0]  coef_q;
  jvns_cell_t                       chain [SqrtBits+1];

  // The pipeline advances unless a finished result is held back.
  assign adv        = !out_valid_o || !out_stall_i;
  assign in_stall_o = !adv;

  // Coefficient registers; the last element sits in the top word.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q <= {CoefOne, {(NumRegs - 2){CfgBits'(0)}}, CoefOne};
    end else if (cfg_we_i) begin
      coef_q[cfg_index_i] <= cfg_data_i;
    end
  end

  jvns_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (in_valid_i),
    .data_i  (in_data_i),
    .cell_o  (chain[0])
  );

  // Row of root cells, most significant bit first.
  for (genvar g = 0; g < SqrtBits; g++) begin : g_cell
    jvns_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .adv_i  (adv),
      .cell_i (chain[g]),
      .cell_o (chain[g+1])
    );
  end

  jvns_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .cell_i  (chain[SqrtBits]),
    .coef_i  (coef_q),
    .valid_o (out_valid_o),
    .data_o  (out_data_o)
  );

endmodule

[design/jvns_checker.sv]
// ----------------------------------------------------------------------------
// Jones vector normalize and split: port checker
// Checks stall behavior and the zero-input result on the top-level ports.
// ----------------------------------------------------------------------------
module jvns_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  input  logic                            in_stall_o,
  input  logic                            out_valid_o,
  input  logic                            out_stall_i,
  input  jvns_pkg::jvns_out_t             out_data_o
);

  // The input side only waits on a held-back result.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a blocked output");

  // A stalled result stays and holds its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_data_o)))
    else $error("stalled result changed");

  // A zero input gives zero vectors on both paths.
  a_zero_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.zero_input) |->
      (out_data_o.one_x_re == '0 && out_data_o.one_x_im == '0 &&
       out_data_o.one_y_re == '0 && out_data_o.one_y_im == '0 &&
       out_data_o.two_x_re == '0 && out_data_o.two_x_im == '0 &&
       out_data_o.two_y_re == '0 && out_data_o.two_y_im == '0))
    else $error("zero input gave nonzero result");

endmodule

bind jones_vector_normalize_split_unit jvns_checker u_jvns_checker (.*);
